>>> rtl/mae_pkg.sv
package mae_pkg;

	localparam int XLEN_DEF = 64;

	// input function codes
	localparam logic [1:0] FN_START = 2'd0;
	localparam logic [1:0] FN_REG   = 2'd1;
	localparam logic [1:0] FN_MEM   = 2'd2;

	// result kinds
	localparam logic [2:0] KIND_RD    = 3'd0;
	localparam logic [2:0] KIND_WR    = 3'd1;
	localparam logic [2:0] KIND_RREQ  = 3'd2;
	localparam logic [2:0] KIND_RWR   = 3'd3;
	localparam logic [2:0] KIND_REDIR = 3'd4;

	// narrow-XLEN behavior of a table row
	localparam logic [1:0] NAR_NONE = 2'd0;
	localparam logic [1:0] NAR_FLW  = 2'd1;
	localparam logic [1:0] NAR_GONE = 2'd2;

	localparam logic [15:0] SEL_C = 16'he003;
	localparam logic [15:0] SEL_W = 16'h707f;
	localparam logic [31:0] LONG_MASK = 32'h0000001c;

	typedef struct packed {
		logic [1:0]  func;
		logic [31:0] insn_word;
		logic [63:0] fault_addr;
		logic [63:0] reg_value;
		logic [7:0]  mem_byte;
	} in_item_t;

	typedef struct packed {
		logic [2:0]  kind;
		logic [63:0] address;
		logic [63:0] data;
		logic [4:0]  reg_index;
		logic        reg_is_fp;
		logic [3:0]  access_bytes;
		logic        last;
	} out_item_t;

	typedef struct packed {
		logic [15:0] code;
		logic [15:0] sel;
		logic [4:0]  shift;
		logic [4:0]  fmask;
		logic [3:0]  add;
		logic        fp;
		logic        ld;
		logic [3:0]  bytes;
		logic        sx;
		logic [1:0]  narrow;
	} op_row_t;

	typedef struct packed {
		logic       hit;
		logic       is_load;
		logic       is_fp;
		logic       sx;
		logic [3:0] width;
		logic [4:0] rnum;
	} dec_t;

	// controller -> datapath
	typedef struct packed {
		logic start;
		logic reg_cap;
		logic mem_cap;
		logic store_emit;
	} cmd_t;

	// datapath -> controller
	typedef struct packed {
		logic [1:0] func;
		logic       hit;
		logic       is_load;
		logic       gather_done;
		logic       store_last;
	} stat_t;

	localparam int NOPS = 27;

	localparam op_row_t OPS [NOPS] = '{
		'{16'h2000, SEL_C, 5'd2,  5'd7,  4'd8, 1'b1, 1'b1, 4'd8, 1'b0, NAR_NONE},
		'{16'h4000, SEL_C, 5'd2,  5'd7,  4'd8, 1'b0, 1'b1, 4'd4, 1'b1, NAR_NONE},
		'{16'h6000, SEL_C, 5'd2,  5'd7,  4'd8, 1'b0, 1'b1, 4'd8, 1'b1, NAR_FLW},
		'{16'ha000, SEL_C, 5'd2,  5'd7,  4'd8, 1'b1, 1'b0, 4'd8, 1'b0, NAR_NONE},
		'{16'hc000, SEL_C, 5'd2,  5'd7,  4'd8, 1'b0, 1'b0, 4'd4, 1'b0, NAR_NONE},
		'{16'he000, SEL_C, 5'd2,  5'd7,  4'd8, 1'b0, 1'b0, 4'd8, 1'b0, NAR_FLW},
		'{16'h2002, SEL_C, 5'd7,  5'd31, 4'd0, 1'b1, 1'b1, 4'd8, 1'b0, NAR_NONE},
		'{16'h4002, SEL_C, 5'd7,  5'd31, 4'd0, 1'b0, 1'b1, 4'd4, 1'b1, NAR_NONE},
		'{16'h6002, SEL_C, 5'd7,  5'd31, 4'd0, 1'b0, 1'b1, 4'd8, 1'b1, NAR_FLW},
		'{16'ha002, SEL_C, 5'd2,  5'd31, 4'd0, 1'b1, 1'b0, 4'd8, 1'b0, NAR_NONE},
		'{16'hc002, SEL_C, 5'd2,  5'd31, 4'd0, 1'b0, 1'b0, 4'd4, 1'b0, NAR_NONE},
		'{16'he002, SEL_C, 5'd2,  5'd31, 4'd0, 1'b0, 1'b0, 4'd8, 1'b0, NAR_FLW},
		'{16'h0003, SEL_W, 5'd7,  5'd31, 4'd0, 1'b0, 1'b1, 4'd1, 1'b1, NAR_NONE},
		'{16'h1003, SEL_W, 5'd7,  5'd31, 4'd0, 1'b0, 1'b1, 4'd2, 1'b1, NAR_NONE},
		'{16'h2003, SEL_W, 5'd7,  5'd31, 4'd0, 1'b0, 1'b1, 4'd4, 1'b1, NAR_NONE},
		'{16'h3003, SEL_W, 5'd7,  5'd31, 4'd0, 1'b0, 1'b1, 4'd8, 1'b1, NAR_GONE},
		'{16'h4003, SEL_W, 5'd7,  5'd31, 4'd0, 1'b0, 1'b1, 4'd1, 1'b0, NAR_NONE},
		'{16'h5003, SEL_W, 5'd7,  5'd31, 4'd0, 1'b0, 1'b1, 4'd2, 1'b0, NAR_NONE},
		'{16'h6003, SEL_W, 5'd7,  5'd31, 4'd0, 1'b0, 1'b1, 4'd4, 1'b0, NAR_NONE},
		'{16'h0023, SEL_W, 5'd20, 5'd31, 4'd0, 1'b0, 1'b0, 4'd1, 1'b0, NAR_NONE},
		'{16'h1023, SEL_W, 5'd20, 5'd31, 4'd0, 1'b0, 1'b0, 4'd2, 1'b0, NAR_NONE},
		'{16'h2023, SEL_W, 5'd20, 5'd31, 4'd0, 1'b0, 1'b0, 4'd4, 1'b0, NAR_NONE},
		'{16'h3023, SEL_W, 5'd20, 5'd31, 4'd0, 1'b0, 1'b0, 4'd8, 1'b0, NAR_GONE},
		'{16'h2007, SEL_W, 5'd7,  5'd31, 4'd0, 1'b1, 1'b1, 4'd4, 1'b0, NAR_NONE},
		'{16'h3007, SEL_W, 5'd7,  5'd31, 4'd0, 1'b1, 1'b1, 4'd8, 1'b0, NAR_NONE},
		'{16'h2027, SEL_W, 5'd20, 5'd31, 4'd0, 1'b1, 1'b0, 4'd4, 1'b0, NAR_NONE},
		'{16'h3027, SEL_W, 5'd20, 5'd31, 4'd0, 1'b1, 1'b0, 4'd8, 1'b0, NAR_NONE}
	};

	// match an instruction against the table; narrow selects the rules for XLEN below 64
	function automatic dec_t decode(input logic [31:0] insn, input logic narrow);
		dec_t d;
		op_row_t row;
		logic found;
		logic [4:0] shifted;
		d = '0;
		row = '0;
		found = 1'b0;
		for (int i = 0; i < NOPS; i++) begin
			if (!found && ((insn & {16'h0000, OPS[i].sel}) == {16'h0000, OPS[i].code})) begin
				found = 1'b1;
				row = OPS[i];
			end
		end
		if (found && narrow && row.narrow == NAR_GONE)
			found = 1'b0;
		shifted = 5'(insn >> row.shift);
		d.hit = found;
		d.is_load = row.ld;
		d.is_fp = row.fp;
		d.sx = row.sx;
		d.width = row.bytes;
		d.rnum = (shifted & row.fmask) + {1'b0, row.add};
		if (narrow && row.narrow == NAR_FLW) begin
			d.is_fp = 1'b1;
			d.width = 4'd4;
			d.sx = 1'b0;
		end
		return d;
	endfunction

endpackage

>>> rtl/mae_ctrl.sv
module mae_ctrl (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               item_valid,
	output logic               item_stall,
	output logic               result_valid,
	input  logic               result_stall,
	output mae_pkg::cmd_t      cmd,
	input  mae_pkg::stat_t     st
);

	localparam logic [1:0] ST_IDLE = 2'd0;
	localparam logic [1:0] ST_WREG = 2'd1;
	localparam logic [1:0] ST_WMEM = 2'd2;
	localparam logic [1:0] ST_STOR = 2'd3;

	logic [1:0] state_q;
	logic [1:0] state_nx;
	logic       out_valid_q;
	logic       adv;
	logic       acc;
	logic       load_out;

	// output register free, or emptied this cycle
	assign adv = !out_valid_q || !result_stall;
	assign item_stall = !(adv && state_q != ST_STOR);
	assign acc = item_valid && !item_stall;

	assign cmd.start      = acc && st.func == mae_pkg::FN_START;
	assign cmd.reg_cap    = acc && st.func == mae_pkg::FN_REG && state_q == ST_WREG;
	assign cmd.mem_cap    = acc && st.func == mae_pkg::FN_MEM && state_q == ST_WMEM;
	assign cmd.store_emit = state_q == ST_STOR && adv;

	assign load_out = cmd.start || cmd.mem_cap || cmd.store_emit;
	assign result_valid = out_valid_q;

	always_comb begin
		state_nx = state_q;
		case (state_q)
			ST_IDLE, ST_WREG, ST_WMEM: begin
				if (cmd.start) begin
					if (!st.hit)
						state_nx = ST_IDLE;
					else if (st.is_load)
						state_nx = ST_WMEM;
					else
						state_nx = ST_WREG;
				end else if (cmd.reg_cap) begin
					state_nx = ST_STOR;
				end else if (cmd.mem_cap && st.gather_done) begin
					state_nx = ST_IDLE;
				end
			end
			ST_STOR: begin
				if (cmd.store_emit && st.store_last)
					state_nx = ST_IDLE;
			end
			default: state_nx = ST_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			out_valid_q <= 1'b0;
		end else begin
			state_q <= state_nx;
			if (load_out)
				out_valid_q <= 1'b1;
			else if (!result_stall)
				out_valid_q <= 1'b0;
		end
	end

	a_no_overwrite: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid_q && result_stall |-> !load_out)
		else $error("result overwritten while stalled");

	a_store_run_closed: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == ST_STOR |-> !acc)
		else $error("item taken during store run");

	a_store_end: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.store_emit && st.store_last |=> state_q == ST_IDLE && out_valid_q)
		else $error("store run did not close");

	a_load_start: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.start && st.hit && st.is_load |=> state_q == ST_WMEM && out_valid_q)
		else $error("load start did not enter byte wait");

endmodule

>>> rtl/mae_dp.sv
module mae_dp #(
	parameter int XLEN = mae_pkg::XLEN_DEF
) (
	input  logic                clk,
	input  mae_pkg::in_item_t   item,
	input  mae_pkg::cmd_t       cmd,
	output mae_pkg::stat_t      st,
	output mae_pkg::out_item_t  result
);

	localparam logic [63:0] XMASK = {64{1'b1}} >> (64 - XLEN);
	localparam logic NARROW = XLEN < 64;

	logic        fp_q;
	logic        sx_q;
	logic [3:0]  width_q;
	logic [4:0]  reg_q;
	logic [63:0] base_q;
	logic [3:0]  cnt_q;
	logic [63:0] gather_q;
	logic [63:0] sdata_q;
	mae_pkg::out_item_t out_q;

	logic [31:0] insn;
	logic        long_enc;
	mae_pkg::dec_t dec;
	logic [3:0]  w_eff;
	logic [3:0]  seen_nx;
	logic [63:0] gath_nx;
	logic [63:0] ext;
	logic [63:0] ld_val;
	logic [7:0]  sbyte_sh;
	logic [63:0] st_addr;
	logic [63:0] rd_addr;

	assign insn = (item.insn_word[1:0] == 2'b11) ? item.insn_word
		: {16'h0000, item.insn_word[15:0]};
	assign long_enc = item.insn_word[1:0] == 2'b11
		&& (item.insn_word & mae_pkg::LONG_MASK) == mae_pkg::LONG_MASK;
	assign dec = mae_pkg::decode(insn, NARROW);

	assign w_eff = (width_q == 4'd0 || width_q > 4'd8) ? 4'd1 : width_q;
	assign seen_nx = cnt_q + 4'd1;
	assign gath_nx = gather_q | ({56'h0, item.mem_byte} << {cnt_q[2:0], 3'b000});
	assign sbyte_sh = 8'(sdata_q >> {cnt_q[2:0], 3'b000});
	assign st_addr = (base_q + {60'h0, cnt_q}) & XMASK;
	assign rd_addr = (base_q + {60'h0, seen_nx}) & XMASK;

	always_comb begin
		ext = 64'h0;
		case (width_q)
			4'd1: if (sx_q && gath_nx[7])  ext = 64'hffff_ffff_ffff_ff00;
			4'd2: if (sx_q && gath_nx[15]) ext = 64'hffff_ffff_ffff_0000;
			4'd4: if (sx_q && gath_nx[31]) ext = 64'hffff_ffff_0000_0000;
			default: ext = 64'h0;
		endcase
		ld_val = gath_nx | ext;
		if (!fp_q)
			ld_val = ld_val & XMASK;
	end

	assign st.func = item.func;
	assign st.hit = dec.hit && !long_enc;
	assign st.is_load = dec.is_load;
	assign st.gather_done = !(seen_nx < width_q);
	assign st.store_last = seen_nx == w_eff;

	always_ff @(posedge clk) begin
		if (cmd.start) begin
			if (st.hit) begin
				fp_q <= dec.is_fp;
				sx_q <= dec.sx;
				width_q <= dec.width;
				reg_q <= dec.rnum;
				base_q <= item.fault_addr & XMASK;
				cnt_q <= 4'd0;
				gather_q <= 64'h0;
				out_q.kind <= dec.is_load ? mae_pkg::KIND_RD : mae_pkg::KIND_RREQ;
				out_q.address <= dec.is_load ? (item.fault_addr & XMASK) : 64'h0;
				out_q.data <= 64'h0;
				out_q.reg_index <= dec.is_load ? 5'd0 : dec.rnum;
				out_q.reg_is_fp <= dec.is_load ? 1'b0 : dec.is_fp;
				out_q.access_bytes <= dec.width;
				out_q.last <= 1'b1;
			end else begin
				out_q.kind <= mae_pkg::KIND_REDIR;
				out_q.address <= item.fault_addr;
				out_q.data <= {32'h0, insn};
				out_q.reg_index <= 5'd0;
				out_q.reg_is_fp <= 1'b0;
				out_q.access_bytes <= 4'd1;
				out_q.last <= 1'b1;
			end
		end else if (cmd.reg_cap) begin
			sdata_q <= item.reg_value;
			cnt_q <= 4'd0;
		end else if (cmd.store_emit) begin
			cnt_q <= seen_nx;
			out_q.kind <= mae_pkg::KIND_WR;
			out_q.address <= st_addr;
			out_q.data <= {56'h0, sbyte_sh};
			out_q.reg_index <= 5'd0;
			out_q.reg_is_fp <= 1'b0;
			out_q.access_bytes <= w_eff;
			out_q.last <= st.store_last;
		end else if (cmd.mem_cap) begin
			gather_q <= gath_nx;
			cnt_q <= seen_nx;
			out_q.access_bytes <= width_q;
			out_q.last <= 1'b1;
			if (!st.gather_done) begin
				out_q.kind <= mae_pkg::KIND_RD;
				out_q.address <= rd_addr;
				out_q.data <= 64'h0;
				out_q.reg_index <= 5'd0;
				out_q.reg_is_fp <= 1'b0;
			end else begin
				out_q.kind <= mae_pkg::KIND_RWR;
				out_q.address <= 64'h0;
				out_q.data <= ld_val;
				out_q.reg_index <= reg_q;
				out_q.reg_is_fp <= fp_q;
			end
		end
	end

	assign result = out_q;

endmodule

>>> rtl/misaligned_access_emulator.sv
// Misaligned load/store emulator for a trapped RV64 (or narrower XLEN) access.
// Send a start item with the faulting instruction word and data address; the
// block decodes the compressed, integer and FP load/store forms and answers
// with one result item per request. A load asks for one byte read at a time:
// return each byte as a memory byte reply, and after the last one the block
// gives the gathered, sign- or zero-extended register write. A store asks for
// the source register; after the register reply it emits one byte write per
// access byte, the final one marked last. An unknown word gives a redirect.
// Rate: a start item or reply is taken whenever the single result register is
// free or being drained outside a store run, so a load runs at one byte per
// reply cycle. A store captures the register value, then emits one byte write
// per cycle (1 to 8) while the result is not stalled, taking no item. Replies
// that do not fit the current wait are taken and dropped without a result.
module misaligned_access_emulator #(
	parameter int XLEN = mae_pkg::XLEN_DEF
) (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                item_valid,
	output logic                item_stall,
	input  mae_pkg::in_item_t   item,
	output logic                result_valid,
	input  logic                result_stall,
	output mae_pkg::out_item_t  result
);

	mae_pkg::cmd_t  cmd;
	mae_pkg::stat_t st;

	// sequence the access: phase, handshakes, result register occupancy
	mae_ctrl u_ctrl (
		.clk          (clk),
		.arst_n       (arst_n),
		.item_valid   (item_valid),
		.item_stall   (item_stall),
		.result_valid (result_valid),
		.result_stall (result_stall),
		.cmd          (cmd),
		.st           (st)
	);

	// decode, hold the pending access, gather bytes, build each result
	mae_dp #(
		.XLEN (XLEN)
	) u_dp (
		.clk    (clk),
		.item   (item),
		.cmd    (cmd),
		.st     (st),
		.result (result)
	);

endmodule
